/* hw/rtl/svpwm_sector_duty_calculator_assert.svh */
// assertion macros for the svpwm duty calculator
// the macros expect clk, and SVPWM_ASSERT also rst, in the scope where they are used
`ifndef SVPWM_SECTOR_DUTY_CALCULATOR_ASSERT_SVH
`define SVPWM_SECTOR_DUTY_CALCULATOR_ASSERT_SVH

`ifndef SYNTHESIS

// check a property on every clock edge outside reset
`define SVPWM_ASSERT(label, prop) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) \
    else $error("svpwm assertion failed");

// check a property on every clock edge, reset included
`define SVPWM_ASSERT_ALWAYS(label, prop) \
  label: assert property (@(posedge clk) (prop)) \
    else $error("svpwm assertion failed");

`else

`define SVPWM_ASSERT(label, prop)
`define SVPWM_ASSERT_ALWAYS(label, prop)

`endif

`endif

/* hw/rtl/svpwm_pkg.sv */
package svpwm_pkg;

  // sqrt(3) in q1.16, rounded to nearest
  localparam logic signed [17:0] SQRT3_Q16 = 18'sd113512;

  // doubled duty to output: add half an lsb, drop sixteen fraction bits
  localparam int unsigned FRAC_SHIFT = 16;
  localparam int unsigned ROUND_BIAS = 32768;

  // sextant codes, v1-v2 through v6-v1
  typedef enum logic [2:0] {
    SECT_0 = 3'd0,
    SECT_1 = 3'd1,
    SECT_2 = 3'd2,
    SECT_3 = 3'd3,
    SECT_4 = 3'd4,
    SECT_5 = 3'd5
  } sector_t;

endpackage

/* hw/rtl/svpwm_sector_duty_calculator.sv */
// channel  | ports                               | handshake
// ---------+-------------------------------------+------------------------------
// request  | alpha, beta                         | start, taken when busy low
// result   | duty_u, duty_v, duty_w, sector,     | done, one cycle, no stall
//          | clipped                             |
//
// one request per cycle while busy is low; three registers: input, sextant and dwell, duty.
// done is registered together with the result, after the request has passed the
// input register and the sextant and dwell register.
// the only multiplier is alpha times the sqrt(3) constant in the second stage.
// busy is high during reset and is cleared by the next clock edge after it; otherwise every
// request is taken. the receiver cannot stall, so nothing in the pipeline waits.
// synchronous reset clears the valid flags; data registers are not reset.
`include "svpwm_sector_duty_calculator_assert.svh"

module svpwm_sector_duty_calculator #(
  parameter int DATA_WIDTH = 16
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  output logic                         busy,
  input  logic signed [DATA_WIDTH-1:0] alpha,
  input  logic signed [DATA_WIDTH-1:0] beta,
  output logic                         done,
  output logic        [DATA_WIDTH-1:0] duty_u,
  output logic        [DATA_WIDTH-1:0] duty_v,
  output logic        [DATA_WIDTH-1:0] duty_w,
  output logic        [2:0]            sector,
  output logic                         clipped
);

  // product width, and the width of the terms and of the doubled duties
  localparam int PW = DATA_WIDTH + 18;
  localparam int XW = DATA_WIDTH + 22;

  localparam logic signed [XW-1:0] ONE_Q  = XW'(1) <<< (DATA_WIDTH + 15);
  localparam logic signed [XW-1:0] BIAS_Q = XW'(svpwm_pkg::ROUND_BIAS);

  logic                         accept;
  logic                         in_valid;
  logic signed [DATA_WIDTH-1:0] a_reg;
  logic signed [DATA_WIDTH-1:0] b_reg;

  logic                         mid_valid;
  svpwm_pkg::sector_t           sec_reg;
  logic signed [XW-1:0]         ta_reg;
  logic signed [XW-1:0]         tb_reg;

  logic signed [PW-1:0]         sa;
  logic signed [XW-1:0]         sax;
  logic signed [XW-1:0]         sbx;
  logic                         a_pos;
  logic                         b_pos;
  svpwm_pkg::sector_t           sec_next;
  logic signed [XW-1:0]         ta_next;
  logic signed [XW-1:0]         tb_next;

  logic signed [XW-1:0]         d_first;
  logic signed [XW-1:0]         d_second;
  logic signed [XW-1:0]         d_third;
  logic signed [XW-1:0]         d_phase [3];
  logic        [DATA_WIDTH-1:0] duty_next [3];
  logic        [2:0]            clip_lane;

  assign accept = start && !busy;

  // control: busy set by reset and cleared after it, then valid flags per stage
  always_ff @(posedge clk) begin
    if (rst) begin
      busy      <= 1'b1;
      in_valid  <= 1'b0;
      mid_valid <= 1'b0;
      done      <= 1'b0;
    end else begin
      busy      <= 1'b0;
      in_valid  <= accept;
      mid_valid <= in_valid;
      done      <= mid_valid;
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (accept) begin
      a_reg <= alpha;
      b_reg <= beta;
    end
  end

  // alpha times sqrt(3), beta scaled to the same format
  assign sa  = PW'(a_reg) * PW'(svpwm_pkg::SQRT3_Q16);
  assign sax = XW'(sa);
  assign sbx = XW'(b_reg) <<< 16;

  assign a_pos = !a_reg[DATA_WIDTH-1] && (a_reg != '0);
  assign b_pos = !b_reg[DATA_WIDTH-1] && (b_reg != '0);

  // sextant from sign tests and the beta against alpha*sqrt(3) compares
  always_comb begin
    if (b_pos) begin
      if (a_pos) begin
        sec_next = (sbx > sax) ? svpwm_pkg::SECT_1 : svpwm_pkg::SECT_0;
      end else begin
        sec_next = (-sbx > sax) ? svpwm_pkg::SECT_2 : svpwm_pkg::SECT_1;
      end
    end else begin
      if (a_pos) begin
        sec_next = (-sbx > sax) ? svpwm_pkg::SECT_4 : svpwm_pkg::SECT_5;
      end else begin
        sec_next = (sbx > sax) ? svpwm_pkg::SECT_3 : svpwm_pkg::SECT_4;
      end
    end
  end

  // dwell terms for the chosen sextant
  always_comb begin
    case (sec_next)
      svpwm_pkg::SECT_0: begin
        ta_next = sbx - sax;
        tb_next = -(sbx <<< 1);
      end
      svpwm_pkg::SECT_1: begin
        ta_next = sax - sbx;
        tb_next = -sax - sbx;
      end
      svpwm_pkg::SECT_2: begin
        ta_next = -(sbx <<< 1);
        tb_next = sax + sbx;
      end
      svpwm_pkg::SECT_3: begin
        ta_next = sbx <<< 1;
        tb_next = sax - sbx;
      end
      svpwm_pkg::SECT_4: begin
        ta_next = sax + sbx;
        tb_next = sbx - sax;
      end
      default: begin
        ta_next = -sax - sbx;
        tb_next = sbx <<< 1;
      end
    endcase
  end

  // sextant and dwell register
  always_ff @(posedge clk) begin
    if (in_valid) begin
      sec_reg <= sec_next;
      ta_reg  <= ta_next;
      tb_reg  <= tb_next;
    end
  end

  // chain the three doubled duties
  assign d_first  = ONE_Q - ta_reg - tb_reg;
  assign d_second = d_first + (ta_reg <<< 1);
  assign d_third  = d_second + (tb_reg <<< 1);

  // route the chain onto phases u, v, w
  always_comb begin
    case (sec_reg)
      svpwm_pkg::SECT_0: begin
        d_phase[0] = d_first;
        d_phase[1] = d_second;
        d_phase[2] = d_third;
      end
      svpwm_pkg::SECT_1: begin
        d_phase[1] = d_first;
        d_phase[0] = d_second;
        d_phase[2] = d_third;
      end
      svpwm_pkg::SECT_2: begin
        d_phase[1] = d_first;
        d_phase[2] = d_second;
        d_phase[0] = d_third;
      end
      svpwm_pkg::SECT_3: begin
        d_phase[2] = d_first;
        d_phase[1] = d_second;
        d_phase[0] = d_third;
      end
      svpwm_pkg::SECT_4: begin
        d_phase[2] = d_first;
        d_phase[0] = d_second;
        d_phase[1] = d_third;
      end
      default: begin
        d_phase[0] = d_first;
        d_phase[2] = d_second;
        d_phase[1] = d_third;
      end
    endcase
  end

  // round half up and saturate each phase
  always_comb begin
    logic signed [XW-1:0] biased;
    logic signed [XW-1:0] scaled;
    for (int i = 0; i < 3; i++) begin
      biased = d_phase[i] + BIAS_Q;
      scaled = biased >>> svpwm_pkg::FRAC_SHIFT;
      if (biased[XW-1]) begin
        duty_next[i] = '0;
        clip_lane[i] = 1'b1;
      end else if (scaled[XW-1:DATA_WIDTH] != '0) begin
        duty_next[i] = '1;
        clip_lane[i] = 1'b1;
      end else begin
        duty_next[i] = scaled[DATA_WIDTH-1:0];
        clip_lane[i] = 1'b0;
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (mid_valid) begin
      duty_u  <= duty_next[0];
      duty_v  <= duty_next[1];
      duty_w  <= duty_next[2];
      sector  <= sec_reg;
      clipped <= |clip_lane;
    end
  end

  // a taken request always shows up later as a result with done
  `SVPWM_ASSERT(a_latency, (start && !busy) |-> ##3 done)
  // reported sextant is always one of the six
  `SVPWM_ASSERT(a_sector_range, done |-> (sector <= 3'd5))
  // reset empties the pipeline and raises busy to hold requests off
  `SVPWM_ASSERT_ALWAYS(a_reset_clear, rst |=> (!done && busy && !in_valid && !mid_valid))
  // a result with all duties at full scale must be flagged
  `SVPWM_ASSERT(a_full_clip,
    (done && (duty_u == '1) && (duty_v == '1) && (duty_w == '1)) |-> clipped)

endmodule
